/* rtl/cpmt_pkg.sv */
package cpmt_pkg;

  // Table depth and derived index widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Address family codes
  localparam logic [1:0] FAM_EMPTY = 2'd0;
  localparam logic [1:0] FAM_V4    = 2'd1;
  localparam logic [1:0] FAM_V6    = 2'd2;

  // Longest legal prefix per family
  localparam logic [7:0] V4_MAX_PLEN = 8'd32;
  localparam logic [7:0] V6_MAX_PLEN = 8'd128;

  typedef struct packed {
    logic [1:0]  family;
    logic [7:0]  prefix;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } entry_t;

  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } qry_t;

endpackage

/* rtl/cpmt_req_if.sv */
interface cpmt_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  entry_index;
  logic [1:0]  family;
  logic [7:0]  prefix_len;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (
    output valid, op, entry_index, family, prefix_len, addr_high, addr_low,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, family, prefix_len, addr_high, addr_low,
    output ready
  );
endinterface

/* rtl/cpmt_rsp_if.sv */
interface cpmt_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic refused;

  modport source (
    output valid, hit, refused,
    input  ready
  );
  modport sink (
    input  valid, hit, refused,
    output ready
  );
endinterface

/* rtl/cpmt_table.sv */
module cpmt_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [cpmt_pkg::IDX_W-1:0]    wr_idx_i,
  input  cpmt_pkg::entry_t              wr_entry_i,
  input  logic                          rd_en_i,
  input  logic [cpmt_pkg::IDX_W-1:0]    rd_idx_i,
  output cpmt_pkg::entry_t              rd_entry_o
);
  import cpmt_pkg::*;

  entry_t               mem [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;
  entry_t               rd_data_q;
  logic                 rd_valid_q;

  // Valid bits stand in for clearing the array at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // An unwritten slot reads as empty
  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/cpmt_match_unit.sv */
module cpmt_match_unit (
  input  cpmt_pkg::entry_t entry_i,
  input  cpmt_pkg::qry_t   qry_i,
  output logic             match_o
);
  import cpmt_pkg::*;

  logic [31:0]  mask_v4;
  logic [127:0] mask_v6;
  logic [31:0]  diff_v4;
  logic [127:0] diff_v6;
  logic         same_fam;

  // Keep the upper prefix bits: mask is the complement of all-ones shifted right
  always_comb begin
    mask_v4  = (entry_i.prefix >= V4_MAX_PLEN) ? '1 : ~({32{1'b1}} >> entry_i.prefix);
    mask_v6  = (entry_i.prefix >= V6_MAX_PLEN) ? '1 : ~({128{1'b1}} >> entry_i.prefix);
    diff_v4  = entry_i.addr_low[31:0] ^ qry_i.addr_low[31:0];
    diff_v6  = {entry_i.addr_high, entry_i.addr_low} ^ {qry_i.addr_high, qry_i.addr_low};
    same_fam = (entry_i.family == qry_i.family);
    match_o  = same_fam &&
               (((qry_i.family == FAM_V4) && ((diff_v4 & mask_v4) == '0)) ||
                ((qry_i.family == FAM_V6) && ((diff_v6 & mask_v6) == '0)));
  end

endmodule

/* rtl/cidr_prefix_match_table_top.sv */
// CIDR prefix table with membership check.
//
// Request channel req_i: op selects a write of one table slot or a lookup
// of an address. Response channel rsp_o carries exactly one transaction per
// request: hit for lookups, refused for writes whose prefix length exceeds
// the family limit (32 for IPv4, 128 for IPv6).
//
// The block handles one request at a time and is not ready while busy.
// A write stores the slot on the accepting edge and goes to ST_DONE; its
// response is loaded into the output register once that register is free.
// A lookup walks the table one slot per cycle through the single match unit
// in ST_SCAN, then passes ST_DRAIN for the last compare and ST_DONE, from
// which its response is loaded into the output register the same way.
// The block returns to idle as a response is loaded, so it takes no new
// request before the last one is finished, and is ready once it is loaded.
//
// Reset clears every slot to empty through per-slot valid bits; the block
// is ready as soon as reset is released. A new request may be accepted
// while the previous response still waits in the output register; when
// the receiver stalls, the finished result holds and further requests wait.
module cidr_prefix_match_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpmt_req_if.sink   req_i,
  cpmt_rsp_if.source rsp_o
);
  import cpmt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  qry_t               qry_q, qry_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               hit_q, hit_d;
  logic               refused_q, refused_d;
  logic               rsp_vld_q, rsp_vld_d;
  logic               rsp_hit_q, rsp_hit_d;
  logic               rsp_ref_q, rsp_ref_d;

  logic               req_acc;
  logic               too_long;
  logic               wr_en;
  entry_t             wr_entry;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_entry;
  logic               match;
  logic               rsp_load;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Refuse a prefix longer than the family allows
  assign too_long = ((req_i.family == FAM_V4) && (req_i.prefix_len > V4_MAX_PLEN)) ||
                    ((req_i.family == FAM_V6) && (req_i.prefix_len > V6_MAX_PLEN));

  // Write the slot straight from the request; out-of-range slots are dropped
  assign wr_en = req_acc && (req_i.op == OP_WRITE) && !too_long &&
                 (32'(req_i.entry_index) < ENTRIES);

  always_comb begin
    wr_entry = '0;
    case (req_i.family)
      FAM_V4: begin
        wr_entry.family   = FAM_V4;
        wr_entry.prefix   = req_i.prefix_len;
        wr_entry.addr_low = {32'd0, req_i.addr_low[31:0]};
      end
      FAM_V6: begin
        wr_entry.family    = FAM_V6;
        wr_entry.prefix    = req_i.prefix_len;
        wr_entry.addr_high = req_i.addr_high;
        wr_entry.addr_low  = req_i.addr_low;
      end
      default: begin
        wr_entry = '0;
      end
    endcase
  end

  assign rd_en  = (state_q == ST_SCAN);
  assign rd_idx = cnt_q[IDX_W-1:0];

  cpmt_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (IDX_W'(req_i.entry_index)),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry)
  );

  // One slot compared per cycle during the scan, on the registered table read
  cpmt_match_unit u_match (
    .entry_i (rd_entry),
    .qry_i   (qry_q),
    .match_o (match)
  );

  assign rsp_load = (state_q == ST_DONE) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    qry_d     = qry_q;
    hit_d     = hit_q;
    refused_d = refused_q;
    cmp_vld_d = (state_q == ST_SCAN);

    // Accumulate the hit from the slot read last cycle
    if (cmp_vld_q && match) begin
      hit_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          hit_d     = 1'b0;
          qry_d     = '{family: req_i.family, addr_high: req_i.addr_high,
                        addr_low: req_i.addr_low};
          cnt_d     = '0;
          if (req_i.op == OP_WRITE) begin
            refused_d = too_long;
            state_d   = ST_DONE;
          end else begin
            refused_d = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ENTRIES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: hold until taken, reload once free
  always_comb begin
    rsp_vld_d = rsp_vld_q;
    rsp_hit_d = rsp_hit_q;
    rsp_ref_d = rsp_ref_q;
    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_vld_d = 1'b1;
      rsp_hit_d = hit_q;
      rsp_ref_d = refused_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q     <= qry_d;
    hit_q     <= hit_d;
    refused_q <= refused_d;
    rsp_hit_q <= rsp_hit_d;
    rsp_ref_q <= rsp_ref_d;
  end

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.hit     = rsp_hit_q;
  assign rsp_o.refused = rsp_ref_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("block ready right after accepting a request");

  a_hit_xor_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.refused))
    else $error("response flags both hit and refused");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < CNT_W'(ENTRIES)))
    else $error("scan counter beyond the table");

  a_write_no_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.op == OP_WRITE)) |=> (state_q == ST_DONE))
    else $error("write request did not go straight to response");
`endif

endmodule
